// ----- src/lfra_pkg.sv -----
`default_nettype none

package lfra_pkg;

  // booking and result field widths
  localparam int ArrW   = 32;
  localparam int DepW   = 32;
  localparam int TagW   = 16;
  localparam int RoomW  = 7;

  // stream data widths, padded to whole bytes
  localparam int SDataW = 80;
  localparam int SUserW = 1;
  localparam int MDataW = 32;
  localparam int MUserW = 1;
  localparam int MPadW  = MDataW - 2 * RoomW - TagW;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StFree = 3'b010,
    StScan = 3'b100
  } state_e;

  // control broadcast to every room cell
  typedef struct packed {
    logic clear;  // free the room unconditionally
    logic rel;    // free the room if its departure is before the arrival
    logic adv;    // search token moves one cell
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/lfra_cell.sv -----
`default_nettype none

module lfra_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lfra_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [lfra_pkg::ArrW-1:0]  arrival_i,
  input  wire logic [lfra_pkg::DepW-1:0]  departure_i,
  input  wire logic                       tok_i,
  output logic                            tok_o,
  output logic                            grant_o
);

  logic                      busy_q, busy_d;
  logic                      tok_q, tok_d;
  logic [lfra_pkg::DepW-1:0] dep_q;

  // token stops at a free room, passes over a busy one
  always_comb begin
    grant_o = ctrl_i.adv & tok_q & ~busy_q;
    tok_o   = tok_q & busy_q;
    tok_d   = ctrl_i.adv ? tok_i : tok_q;
  end

  // occupancy update: clear, release on early departure, take on grant
  always_comb begin
    busy_d = busy_q;
    if (ctrl_i.clear) begin
      busy_d = 1'b0;
    end else if (ctrl_i.rel && busy_q && (dep_q < arrival_i)) begin
      busy_d = 1'b0;
    end
    if (grant_o) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      tok_q  <= tok_d;
    end
  end

  // departure is only looked at while the room is busy
  always_ff @(posedge clk_i) begin
    if (grant_o) begin
      dep_q <= departure_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/lfra_ctrl.sv -----
`default_nettype none

module lfra_ctrl #(
  parameter int Rooms = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [lfra_pkg::SDataW-1:0]  s_axis_tdata,
  input  wire logic [lfra_pkg::SUserW-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [lfra_pkg::MDataW-1:0]       m_axis_tdata,
  output logic [lfra_pkg::MUserW-1:0]       m_axis_tuser,
  output lfra_pkg::cell_ctrl_t              cell_ctrl_o,
  output logic [lfra_pkg::ArrW-1:0]         arrival_o,
  output logic [lfra_pkg::DepW-1:0]         departure_o,
  output logic                              start_o,
  input  wire logic                         grant_any_i,
  input  wire logic                         last_pass_i
);

  localparam int IdxW = (Rooms > 1) ? $clog2(Rooms) : 1;
  localparam int NumW = $clog2(Rooms + 1);

  lfra_pkg::state_e           state_q, state_d;
  logic [lfra_pkg::ArrW-1:0]  arr_q;
  logic [lfra_pkg::DepW-1:0]  dep_q;
  logic [lfra_pkg::TagW-1:0]  tag_q;
  logic                       first_q;
  logic [IdxW-1:0]            idx_q;
  logic [NumW-1:0]            high_q;
  logic [NumW-1:0]            high_new;
  logic [NumW-1:0]            room_num;
  logic                       m_valid_q;
  logic [lfra_pkg::MDataW-1:0] m_data_q;
  logic [lfra_pkg::MUserW-1:0] m_user_q;
  logic                       in_xfer;
  logic                       slot_free;
  logic                       scan_adv;
  logic                       done_grant;
  logic                       done_full;

  // handshake and search step enables
  always_comb begin
    s_axis_tready = (state_q == lfra_pkg::StIdle);
    in_xfer       = s_axis_tvalid & s_axis_tready;
    slot_free     = ~m_valid_q | m_axis_tready;
    scan_adv      = (state_q == lfra_pkg::StScan) & slot_free;
    done_grant    = scan_adv & grant_any_i;
    done_full     = scan_adv & last_pass_i;
    room_num      = NumW'(idx_q) + NumW'(1);
    high_new      = (room_num > high_q) ? room_num : high_q;
  end

  // cell broadcast
  always_comb begin
    cell_ctrl_o.clear = (state_q == lfra_pkg::StFree) & first_q;
    cell_ctrl_o.rel   = (state_q == lfra_pkg::StFree);
    cell_ctrl_o.adv   = (state_q == lfra_pkg::StFree) | scan_adv;
    start_o           = (state_q == lfra_pkg::StFree);
    arrival_o         = arr_q;
    departure_o       = dep_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfra_pkg::StIdle: if (in_xfer) state_d = lfra_pkg::StFree;
      lfra_pkg::StFree: state_d = lfra_pkg::StScan;
      lfra_pkg::StScan: if (done_grant || done_full) state_d = lfra_pkg::StIdle;
      default:          state_d = lfra_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfra_pkg::StIdle;
      high_q    <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // highest room so far
      if ((state_q == lfra_pkg::StFree) && first_q) begin
        high_q <= '0;
      end else if (done_grant) begin
        high_q <= high_new;
      end
      // token position
      if (state_q == lfra_pkg::StFree) begin
        idx_q <= '0;
      end else if (scan_adv && !done_grant && !done_full) begin
        idx_q <= idx_q + IdxW'(1);
      end
      // output register
      if (done_grant || done_full) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // booking capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      arr_q   <= s_axis_tdata[31:0];
      dep_q   <= s_axis_tdata[63:32];
      tag_q   <= s_axis_tdata[79:64];
      first_q <= s_axis_tuser[0];
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (done_grant) begin
      m_data_q <= {lfra_pkg::MPadW'(0), tag_q,
                   lfra_pkg::RoomW'(high_new), lfra_pkg::RoomW'(room_num)};
      m_user_q <= 1'b0;
    end else if (done_full) begin
      m_data_q <= {lfra_pkg::MPadW'(0), tag_q,
                   lfra_pkg::RoomW'(high_q), lfra_pkg::RoomW'(0)};
      m_user_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ----- src/lowest_free_room_allocator_unit.sv -----
// flow: a booking's transfer is followed by a release step, then a search token
//   that walks the room cells one per cycle from room 1 until it reaches a free
//   room, or passes the last room for a full result
// a new booking is taken only after the previous search has ended; the walk
//   pauses while the previous result waits
// reset: asynchronous, active low; all rooms free, highest room 0, no result
`default_nettype none

module lowest_free_room_allocator_unit #(
  parameter int ROOMS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // arrival [31:0], departure [63:32], guest_tag [79:64]
  input  wire logic [lfra_pkg::SDataW-1:0]  s_axis_tdata,
  // first [0]
  input  wire logic [lfra_pkg::SUserW-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // room [6:0], rooms_used [13:7], tag_out [29:14], zero [31:30]
  output logic [lfra_pkg::MDataW-1:0]       m_axis_tdata,
  // full_res [0]
  output logic [lfra_pkg::MUserW-1:0]       m_axis_tuser
);

  lfra_pkg::cell_ctrl_t        cell_ctrl;
  logic [lfra_pkg::ArrW-1:0]   arrival;
  logic [lfra_pkg::DepW-1:0]   departure;
  logic                        start;
  logic [ROOMS:0]              tok;
  logic [ROOMS-1:0]            grant;

  lfra_ctrl #(
    .Rooms (ROOMS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cell_ctrl_o   (cell_ctrl),
    .arrival_o     (arrival),
    .departure_o   (departure),
    .start_o       (start),
    .grant_any_i   (|grant),
    .last_pass_i   (tok[ROOMS])
  );

  // search token enters at room 1
  assign tok[0] = start;

  // one cell per room, token handed to the next room each cycle while the search advances
  for (genvar gi = 0; gi < ROOMS; gi++) begin : g_room
    lfra_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .arrival_i   (arrival),
      .departure_i (departure),
      .tok_i       (tok[gi]),
      .tok_o       (tok[gi+1]),
      .grant_o     (grant[gi])
    );
  end

endmodule

`default_nettype wire

// ----- src/lfra_checker.sv -----
`default_nettype none

module lfra_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [lfra_pkg::MDataW-1:0]  m_axis_tdata,
  input wire logic [lfra_pkg::MUserW-1:0]  m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // a full result carries no room
  a_full_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[6:0] == 7'd0)
    else $error("full result with a room number");

  // one booking at a time: input closes right after a transfer
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("booking taken while another is in search");

endmodule

bind lowest_free_room_allocator_unit lfra_checker u_lfra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
